/* hdl/wpus_pkg.sv */
package wpus_pkg;

    localparam int CAPACITY = 1024;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int QDEPTH = 2;
    localparam int QAW = $clog2(QDEPTH);
    localparam int QCW = $clog2(QDEPTH + 1);

    localparam logic ACT_ARRIVE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    localparam logic [47:0] PEN_MAX = {48{1'b1}};

    typedef struct packed {
        logic        action;
        logic [15:0] work;
        logic [15:0] weight;
    } t_in_word;

    typedef struct packed {
        logic [47:0] penalty;
        logic        served;
        logic [15:0] served_weight;
        logic        dropped;
        logic [10:0] occupancy;
    } t_out_word;

    typedef enum logic [1:0] {
        CMD_SKIP,
        CMD_INSERT,
        CMD_TICK
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [15:0] work;
        logic [15:0] weight;
        logic [31:0] product;
    } t_job_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_TOP_RD,
        ST_TOP_USE,
        ST_LAST_RD,
        ST_LAST_USE,
        ST_DN_RDL,
        ST_DN_RDR,
        ST_DN_CMP,
        ST_DONE
    } t_state;

endpackage

/* hdl/wpus_front.sv */
module wpus_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  wpus_pkg::t_in_word    i_word,
    output logic                  o_valid,
    input  logic                  i_ready,
    output wpus_pkg::t_job_cmd    o_cmd
);

    localparam int QAW = wpus_pkg::QAW;
    localparam int QCW = wpus_pkg::QCW;

    wpus_pkg::t_job_cmd r_q [wpus_pkg::QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QCW-1:0] r_cnt;
    wpus_pkg::t_job_cmd n_cmd;
    logic push;
    logic pop;

    assign o_ready = (r_cnt != QCW'(wpus_pkg::QDEPTH));
    assign o_valid = (r_cnt != QCW'(0));
    assign o_cmd = r_q[r_rp];
    assign push = i_valid && o_ready;
    assign pop = o_valid && i_ready;

    always_comb begin
        n_cmd.work = i_word.work;
        n_cmd.weight = i_word.weight;
        n_cmd.product = 32'(i_word.work) * 32'(i_word.weight);
        if (i_word.action == wpus_pkg::ACT_TICK) begin
            n_cmd.cmd = wpus_pkg::CMD_TICK;
        end else if (i_word.work == 16'd0) begin
            n_cmd.cmd = wpus_pkg::CMD_SKIP;
        end else begin
            n_cmd.cmd = wpus_pkg::CMD_INSERT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_cmd;
        end
        if (!i_rst_n) begin
            r_wp <= QAW'(0);
            r_rp <= QAW'(0);
            r_cnt <= QCW'(0);
        end else begin
            if (push) begin
                r_wp <= (r_wp == QAW'(wpus_pkg::QDEPTH - 1)) ? QAW'(0) : r_wp + QAW'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == QAW'(wpus_pkg::QDEPTH - 1)) ? QAW'(0) : r_rp + QAW'(1);
            end
            r_cnt <= r_cnt + QCW'(push) - QCW'(pop);
        end
    end

endmodule

/* hdl/wpus_back.sv */
module wpus_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  wpus_pkg::t_job_cmd    i_cmd,
    output logic                  o_valid,
    input  logic                  i_ready,
    output wpus_pkg::t_out_word   o_word
);

    localparam int AW = wpus_pkg::AW;
    localparam int CW = wpus_pkg::CW;

    logic [31:0] r_mem [wpus_pkg::CAPACITY];
    logic [31:0] r_rd;
    logic [AW-1:0] rd_addr;
    logic rd_en;
    logic [AW-1:0] wr_addr;
    logic [31:0] wr_data;
    logic wr_en;

    wpus_pkg::t_state r_state, n_state;
    wpus_pkg::t_job_cmd r_cmd;
    logic [CW-1:0] r_count, n_count;
    logic [47:0] r_pen, n_pen;
    logic [AW-1:0] r_pos, n_pos;
    logic [31:0] r_cur, n_cur;
    logic [31:0] r_left, n_left;
    logic [31:0] r_par, n_par;
    logic r_served, n_served;
    logic [15:0] r_sw, n_sw;
    logic r_drop, n_drop;
    logic r_ovalid, n_ovalid;
    wpus_pkg::t_out_word r_out, n_out;

    logic [CW:0] lidx;
    logic [CW:0] ridx;
    logic [AW-1:0] parent;
    logic [48:0] sum;
    logic [15:0] topw;
    logic [15:0] topk;

    assign o_ready = (r_state == wpus_pkg::ST_IDLE);
    assign o_valid = r_ovalid;
    assign o_word = r_out;

    assign lidx = (CW + 1)'({r_pos, 1'b1});
    assign ridx = lidx + (CW + 1)'(1);
    assign parent = AW'((r_pos - AW'(1)) >> 1);
    assign sum = {1'b0, r_pen} + 49'(r_cmd.product);
    assign topw = r_rd[31:16];
    assign topk = r_rd[15:0] - 16'd1;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wpus_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = wpus_pkg::ST_DECIDE;
                end
            end
            wpus_pkg::ST_DECIDE: begin
                if (r_ovalid && !i_ready) begin
                    n_state = wpus_pkg::ST_DECIDE;
                end else if (r_cmd.cmd == wpus_pkg::CMD_INSERT
                             && r_count < CW'(wpus_pkg::CAPACITY)) begin
                    n_state = (r_count == CW'(0)) ? wpus_pkg::ST_DONE
                                                   : wpus_pkg::ST_UP_RD;
                end else if (r_cmd.cmd == wpus_pkg::CMD_TICK
                             && r_count != CW'(0)) begin
                    n_state = wpus_pkg::ST_TOP_RD;
                end else begin
                    n_state = wpus_pkg::ST_DONE;
                end
            end
            wpus_pkg::ST_UP_RD:  n_state = wpus_pkg::ST_UP_CMP;
            wpus_pkg::ST_UP_CMP: begin
                if (r_rd[31:16] >= r_cur[31:16] || parent == AW'(0)) begin
                    n_state = wpus_pkg::ST_DONE;
                end else begin
                    n_state = wpus_pkg::ST_UP_RD;
                end
            end
            wpus_pkg::ST_TOP_RD:  n_state = wpus_pkg::ST_TOP_USE;
            wpus_pkg::ST_TOP_USE: begin
                if (topk != 16'd0 || r_count == CW'(1)) begin
                    n_state = wpus_pkg::ST_DONE;
                end else begin
                    n_state = wpus_pkg::ST_LAST_RD;
                end
            end
            wpus_pkg::ST_LAST_RD:  n_state = wpus_pkg::ST_LAST_USE;
            wpus_pkg::ST_LAST_USE: n_state = wpus_pkg::ST_DN_RDL;
            wpus_pkg::ST_DN_RDL: begin
                if (lidx >= (CW + 1)'(r_count)) begin
                    n_state = wpus_pkg::ST_DONE;
                end else begin
                    n_state = wpus_pkg::ST_DN_RDR;
                end
            end
            wpus_pkg::ST_DN_RDR: n_state = wpus_pkg::ST_DN_CMP;
            wpus_pkg::ST_DN_CMP: begin
                if (r_left[31:16] <= r_cur[31:16]
                    && (ridx >= (CW + 1)'(r_count)
                        || r_rd[31:16] <= r_par[31:16])) begin
                    n_state = wpus_pkg::ST_DONE;
                end else begin
                    n_state = wpus_pkg::ST_DN_RDL;
                end
            end
            wpus_pkg::ST_DONE: n_state = wpus_pkg::ST_IDLE;
            default:           n_state = wpus_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_count = r_count;
        n_pen = r_pen;
        n_pos = r_pos;
        n_cur = r_cur;
        n_left = r_left;
        n_par = r_par;
        n_served = r_served;
        n_sw = r_sw;
        n_drop = r_drop;
        n_ovalid = r_ovalid && !i_ready;
        n_out = r_out;
        rd_en = 1'b0;
        rd_addr = r_pos;
        wr_en = 1'b0;
        wr_addr = r_pos;
        wr_data = r_cur;
        unique case (r_state)
            wpus_pkg::ST_IDLE: begin
                n_served = 1'b0;
                n_sw = 16'd0;
                n_drop = 1'b0;
            end
            wpus_pkg::ST_DECIDE: begin
                if (!(r_ovalid && !i_ready)) begin
                    if (r_cmd.cmd == wpus_pkg::CMD_INSERT) begin
                        if (r_count >= CW'(wpus_pkg::CAPACITY)) begin
                            n_drop = 1'b1;
                        end else begin
                            n_pen = sum[48] ? wpus_pkg::PEN_MAX : sum[47:0];
                            n_cur = {r_cmd.weight, r_cmd.work};
                            n_pos = AW'(r_count);
                            n_count = r_count + CW'(1);
                            wr_en = 1'b1;
                            wr_addr = AW'(r_count);
                            wr_data = {r_cmd.weight, r_cmd.work};
                        end
                    end else if (r_cmd.cmd == wpus_pkg::CMD_TICK
                                 && r_count != CW'(0)) begin
                        n_pos = AW'(0);
                    end
                end
            end
            wpus_pkg::ST_UP_RD: begin
                rd_en = 1'b1;
                rd_addr = parent;
            end
            wpus_pkg::ST_UP_CMP: begin
                if (r_rd[31:16] < r_cur[31:16]) begin
                    wr_en = 1'b1;
                    wr_addr = r_pos;
                    wr_data = r_rd;
                    n_pos = parent;
                end
            end
            wpus_pkg::ST_TOP_RD: begin
                rd_en = 1'b1;
                rd_addr = AW'(0);
            end
            wpus_pkg::ST_TOP_USE: begin
                n_served = 1'b1;
                n_sw = topw;
                n_pen = (r_pen >= 48'(topw)) ? r_pen - 48'(topw) : 48'd0;
                if (topk != 16'd0) begin
                    wr_en = 1'b1;
                    wr_addr = AW'(0);
                    wr_data = {topw, topk};
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            wpus_pkg::ST_LAST_RD: begin
                rd_en = 1'b1;
                rd_addr = AW'(r_count);
            end
            wpus_pkg::ST_LAST_USE: begin
                n_cur = r_rd;
                n_par = r_rd;
                n_pos = AW'(0);
            end
            wpus_pkg::ST_DN_RDL: begin
                if (lidx >= (CW + 1)'(r_count)) begin
                    wr_en = 1'b1;
                    wr_addr = r_pos;
                    wr_data = r_cur;
                end else begin
                    rd_en = 1'b1;
                    rd_addr = AW'(lidx);
                    n_par = r_cur;
                end
            end
            wpus_pkg::ST_DN_RDR: begin
                n_left = r_rd;
                if (r_rd[31:16] > r_par[31:16]) begin
                    n_par = r_rd;
                end
                rd_en = ridx < (CW + 1)'(r_count);
                rd_addr = AW'(ridx);
            end
            wpus_pkg::ST_DN_CMP: begin
                if (ridx < (CW + 1)'(r_count) && r_rd[31:16] > r_par[31:16]) begin
                    wr_en = 1'b1;
                    wr_addr = r_pos;
                    wr_data = r_rd;
                    n_pos = AW'(ridx);
                end else if (r_par[31:16] != r_cur[31:16]
                             || r_left[31:16] > r_cur[31:16]) begin
                    wr_en = 1'b1;
                    wr_addr = r_pos;
                    wr_data = r_left;
                    n_pos = AW'(lidx);
                end else begin
                    wr_en = 1'b1;
                    wr_addr = r_pos;
                    wr_data = r_cur;
                end
            end
            wpus_pkg::ST_DONE: begin
                if (n_state == wpus_pkg::ST_IDLE) begin
                    n_ovalid = 1'b1;
                    n_out.penalty = r_pen;
                    n_out.served = r_served;
                    n_out.served_weight = r_sw;
                    n_out.dropped = r_drop;
                    n_out.occupancy = 11'(r_count);
                end
                if (r_cmd.cmd == wpus_pkg::CMD_INSERT && !r_drop) begin
                    wr_en = 1'b1;
                    wr_addr = r_pos;
                    wr_data = r_cur;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_cur <= n_cur;
        r_left <= n_left;
        r_par <= n_par;
        r_sw <= n_sw;
        r_out <= n_out;
        if (r_state == wpus_pkg::ST_IDLE && i_valid) begin
            r_cmd <= i_cmd;
        end
        if (!i_rst_n) begin
            r_state <= wpus_pkg::ST_IDLE;
            r_count <= CW'(0);
            r_pen <= 48'd0;
            r_served <= 1'b0;
            r_drop <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pen <= n_pen;
            r_served <= n_served;
            r_drop <= n_drop;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

/* hdl/weighted_priority_unit_scheduler.sv */
// An arrival into an empty heap, a drop or a skipped word needs no heap walk; an
// insert sifts the new job up, and a tick serves the top job and, once its work is
// used up, sifts the last job down. The heap engine takes one word at a time, and
// its heap memory of 1024 entries has one read port and one write port.
// Reset clears the job count, the penalty and all handshakes.
module weighted_priority_unit_scheduler (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  wpus_pkg::t_in_word    i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output wpus_pkg::t_out_word   o_data
);

    logic q_valid;
    logic q_ready;
    wpus_pkg::t_job_cmd q_cmd;

    wpus_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_word  (i_data),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_cmd   (q_cmd)
    );

    wpus_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_cmd   (q_cmd),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_word  (o_data)
    );

endmodule

/* hdl/wpus_checker.sv */
module wpus_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  o_ready,
    input  wpus_pkg::t_in_word    i_data,
    input  logic                  o_valid,
    input  logic                  i_ready,
    input  wpus_pkg::t_out_word   o_data
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output word changed while stalled");

    a_sw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.served |-> o_data.served_weight == 16'd0)
        else $error("served weight without service");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_data.served && o_data.dropped))
        else $error("served and dropped together");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind weighted_priority_unit_scheduler wpus_checker u_checker (.*);

/* dv/weighted_priority_unit_scheduler_checker.sv */
`timescale 1ns / 1ps

module weighted_priority_unit_scheduler_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_ready_in,
    input  wpus_pkg::t_in_word    i_data,
    input  logic                  i_valid_out,
    input  logic                  i_ready,
    input  wpus_pkg::t_out_word   i_result,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int EXP_DEPTH = 16;

    logic [31:0]         job_heap [wpus_pkg::CAPACITY];
    int unsigned         job_total;
    logic [47:0]         penalty_sum;
    wpus_pkg::t_out_word exp_mem [EXP_DEPTH];
    int                  exp_wr;
    int                  exp_rd;
    int                  mismatch_count;

    assign o_fail_count = mismatch_count;
    assign o_pending = exp_wr - exp_rd;

    function automatic void heap_swap(int unsigned a, int unsigned b);
        logic [31:0] t;
        t = job_heap[a];
        job_heap[a] = job_heap[b];
        job_heap[b] = t;
    endfunction

    function automatic wpus_pkg::t_out_word schedule_word(wpus_pkg::t_in_word w);
        wpus_pkg::t_out_word r;
        int unsigned pos, up, lc, rc, best;
        logic [47:0] add;
        logic [15:0] left;
        r = '0;
        if (w.action == wpus_pkg::ACT_ARRIVE) begin
            if (w.work != 0) begin
                if (job_total >= wpus_pkg::CAPACITY) begin
                    r.dropped = 1'b1;
                end else begin
                    job_heap[job_total] = {w.weight, w.work};
                    pos = job_total;
                    job_total++;
                    while (pos > 0) begin
                        up = (pos - 1) / 2;
                        if (job_heap[up][31:16] >= job_heap[pos][31:16]) break;
                        heap_swap(up, pos);
                        pos = up;
                    end
                    add = 48'(w.work) * 48'(w.weight);
                    if (add > wpus_pkg::PEN_MAX - penalty_sum) penalty_sum = wpus_pkg::PEN_MAX;
                    else penalty_sum = penalty_sum + add;
                end
            end
        end else if (job_total > 0) begin
            r.served = 1'b1;
            r.served_weight = job_heap[0][31:16];
            if (penalty_sum >= 48'(r.served_weight)) penalty_sum -= 48'(r.served_weight);
            else penalty_sum = '0;
            left = job_heap[0][15:0] - 16'd1;
            if (left != 0) begin
                job_heap[0][15:0] = left;
            end else begin
                job_total--;
                job_heap[0] = job_heap[job_total];
                pos = 0;
                forever begin
                    lc = 2 * pos + 1;
                    rc = lc + 1;
                    best = pos;
                    if (lc < job_total && job_heap[lc][31:16] > job_heap[best][31:16])
                        best = lc;
                    if (rc < job_total && job_heap[rc][31:16] > job_heap[best][31:16])
                        best = rc;
                    if (best == pos) break;
                    heap_swap(best, pos);
                    pos = best;
                end
            end
        end
        r.penalty = penalty_sum;
        r.occupancy = 11'(job_total);
        return r;
    endfunction

    always @(posedge i_clk) begin
        wpus_pkg::t_out_word e;
        if (!i_rst_n) begin
            job_total = 0;
            penalty_sum = '0;
            exp_wr = 0;
            exp_rd = 0;
            mismatch_count <= 0;
        end else begin
            if (i_valid && i_ready_in) begin
                exp_mem[exp_wr % EXP_DEPTH] = schedule_word(i_data);
                exp_wr++;
            end
            if (i_valid_out && i_ready) begin
                if (exp_wr == exp_rd) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10) $display("Unexpected word %h", i_result);
                end else begin
                    e = exp_mem[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    if (e !== i_result) begin
                        mismatch_count <= mismatch_count + 1;
                        if (mismatch_count < 10)
                            $display({"Mismatch: expected pen=%0d srv=%0b sw=%0d drp=%0b ",
                                      "occ=%0d, got pen=%0d srv=%0b sw=%0d drp=%0b occ=%0d"},
                                e.penalty, e.served, e.served_weight, e.dropped, e.occupancy,
                                i_result.penalty, i_result.served, i_result.served_weight,
                                i_result.dropped, i_result.occupancy);
                    end
                end
            end
        end
    end
endmodule

/* dv/weighted_priority_unit_scheduler_test.sv */
`timescale 1ns / 1ps

module weighted_priority_unit_scheduler_test;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                i_ready = 1'b0;
    wpus_pkg::t_in_word  i_data = '0;
    logic                o_ready, o_valid;
    wpus_pkg::t_out_word o_data;
    int                  fail_count, pending;
    int                  idle_cycles = 0;
    bit                  calm = 1'b0;

    always #5 i_clk = ~i_clk;

    weighted_priority_unit_scheduler dut (.*);

    weighted_priority_unit_scheduler_checker result_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_ready_in(o_ready),
        .i_data(i_data), .i_valid_out(o_valid), .i_ready(i_ready), .i_result(o_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                n = $urandom_range(1, 10);
                repeat (n - 1) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic send_word(logic act, logic [15:0] wk, logic [15:0] wt);
        int n;
        if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 10);
            i_valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
        i_data <= '{action: act, work: wk, weight: wt};
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic stop_words;
        i_valid <= 1'b0;
    endtask

    task automatic send_day(int jobs, int max_work);
        for (int j = 0; j < jobs; j++)
            send_word(wpus_pkg::ACT_ARRIVE, 16'($urandom_range(1, max_work)), 16'($urandom));
        send_word(wpus_pkg::ACT_TICK, 16'($urandom), 16'($urandom));
    endtask

    initial begin
        int sent;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_word(wpus_pkg::ACT_TICK, 16'hFFFF, 16'hFFFF);
        send_word(wpus_pkg::ACT_ARRIVE, 16'd0, 16'd500);
        send_word(wpus_pkg::ACT_ARRIVE, 16'hFFFF, 16'hFFFF);
        send_word(wpus_pkg::ACT_ARRIVE, 16'd1, 16'd0);
        send_word(wpus_pkg::ACT_ARRIVE, 16'd2, 16'd7);
        send_word(wpus_pkg::ACT_ARRIVE, 16'd1, 16'd7);
        send_word(wpus_pkg::ACT_ARRIVE, 16'd3, 16'hFFFF);
        for (int j = 0; j < 10; j++) send_word(wpus_pkg::ACT_TICK, 16'd0, 16'd0);
        stop_words();
        wait (pending == 0);
        @(negedge i_clk);
        for (int j = 0; j < 1030; j++)
            send_word(wpus_pkg::ACT_ARRIVE, 16'($urandom_range(1, 3)), 16'($urandom));
        sent = 1047;
        while (sent < 1250) begin
            send_day($urandom_range(0, 2), 4);
            sent += 3;
        end
        for (int j = 0; j < 120; j++) begin
            if (j == 90) calm = 1'b1;
            if ($urandom_range(0, 3) == 0)
                send_word(wpus_pkg::ACT_TICK, 16'($urandom), 16'($urandom));
            else send_day($urandom_range(0, 2), $urandom_range(0, 1) ? 3 : 65535);
        end
        stop_words();
        wait (pending == 0);
        repeat (60) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end
endmodule
